// ----- hw/rtl/dram_frrr_command_scheduler_core_defines.svh -----
// Assertion helpers shared by the scheduler RTL.
`ifndef DRAM_FRRR_COMMAND_SCHEDULER_CORE_DEFINES_SVH
`define DRAM_FRRR_COMMAND_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication under reset.
`define FRRR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// Next-cycle implication under reset.
`define FRRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

// ----- hw/rtl/frrr_pkg.sv -----
`timescale 1ns / 1ps
package frrr_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int MAX_THREADS = 16;

	localparam logic [63:0] QUEUE_MASK =
		(QUEUE_DEPTH >= 64) ? {64{1'b1}} : ((64'd1 << QUEUE_DEPTH) - 64'd1);

	localparam logic ACT_STORE = 1'b0;
	localparam logic ACT_SCHED = 1'b1;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_HIGH_WM   = 2'd0,
		REG_LOW_WM    = 2'd1,
		REG_MIN_DRAIN = 2'd2,
		REG_CORE_CNT  = 2'd3
	} frrr_reg_t;

	typedef struct packed {
		logic [6:0] high_watermark;
		logic [6:0] low_watermark;
		logic [6:0] min_drain_writes;
		logic [4:0] core_count;
	} frrr_cfg_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic load;
		logic commit;
	} frrr_cmd_t;

	typedef struct packed {
		logic       found;
		logic [5:0] idx;
	} frrr_pick_t;

	// Lowest set bit, slot 0 first.
	function automatic frrr_pick_t lowest_set(input logic [63:0] m);
		frrr_pick_t r;
		r.found = 1'b0;
		r.idx   = 6'd0;
		for (int i = 63; i >= 0; i--) begin
			if (m[i]) begin
				r.found = 1'b1;
				r.idx   = 6'(i);
			end
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/frrr_req_if.sv -----
`timescale 1ns / 1ps
interface frrr_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [5:0]  slot;
	logic [3:0]  owner_thread;
	logic [63:0] read_valid_mask;
	logic [63:0] read_issuable_mask;
	logic [63:0] read_hit_mask;
	logic [6:0]  write_count;
	logic [63:0] write_issuable_mask;
	logic [63:0] write_hit_mask;

	modport source (
		output valid, action, slot, owner_thread, read_valid_mask, read_issuable_mask,
			read_hit_mask, write_count, write_issuable_mask, write_hit_mask,
		input  ready
	);
	modport sink (
		input  valid, action, slot, owner_thread, read_valid_mask, read_issuable_mask,
			read_hit_mask, write_count, write_issuable_mask, write_hit_mask,
		output ready
	);
endinterface

// ----- hw/rtl/frrr_rsp_if.sv -----
`timescale 1ns / 1ps
interface frrr_rsp_if;
	logic       valid;
	logic       ready;
	logic       issue_valid;
	logic       issue_is_write;
	logic [5:0] issue_slot;
	logic       drain_active;
	logic [3:0] next_thread;

	modport source (
		output valid, issue_valid, issue_is_write, issue_slot, drain_active, next_thread,
		input  ready
	);
	modport sink (
		input  valid, issue_valid, issue_is_write, issue_slot, drain_active, next_thread,
		output ready
	);
endinterface

// ----- hw/rtl/frrr_regs.sv -----
`timescale 1ns / 1ps
module frrr_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output frrr_pkg::frrr_cfg_t cfg
);
	import frrr_pkg::*;

	frrr_cfg_t cfg_q;
	frrr_reg_t sel;
	logic      wr_en;

	assign pready = 1'b1;
	assign sel    = frrr_reg_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_watermark   <= 7'd40;
			cfg_q.low_watermark    <= 7'd32;
			cfg_q.min_drain_writes <= 7'd1;
			cfg_q.core_count       <= 5'd4;
		end else if (wr_en) begin
			case (sel)
				REG_HIGH_WM:   cfg_q.high_watermark   <= pwdata[6:0];
				REG_LOW_WM:    cfg_q.low_watermark    <= pwdata[6:0];
				REG_MIN_DRAIN: cfg_q.min_drain_writes <= pwdata[6:0];
				REG_CORE_CNT:  cfg_q.core_count       <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_HIGH_WM:   prdata = {25'd0, cfg_q.high_watermark};
			REG_LOW_WM:    prdata = {25'd0, cfg_q.low_watermark};
			REG_MIN_DRAIN: prdata = {25'd0, cfg_q.min_drain_writes};
			REG_CORE_CNT:  prdata = {27'd0, cfg_q.core_count};
			default:       prdata = 32'd0;
		endcase
	end
endmodule

// ----- hw/rtl/frrr_ctrl.sv -----
`timescale 1ns / 1ps
module frrr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	output frrr_pkg::frrr_cmd_t cmd
);
	import frrr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.load   = in_valid & in_ready;
	// Commit once the output register is free or being drained this cycle.
	assign cmd.commit = (state_q == ST_EXEC) & (~out_valid_q | out_ready);
	assign out_valid  = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (cmd.load) state_d = ST_EXEC;
			ST_EXEC: if (cmd.commit) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

// ----- hw/rtl/frrr_dp.sv -----
`timescale 1ns / 1ps
module frrr_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  frrr_pkg::frrr_cmd_t cmd,
	input  frrr_pkg::frrr_cfg_t cfg,
	input  logic                action,
	input  logic [5:0]          slot,
	input  logic [3:0]          owner_thread,
	input  logic [63:0]         read_valid_mask,
	input  logic [63:0]         read_issuable_mask,
	input  logic [63:0]         read_hit_mask,
	input  logic [6:0]          write_count,
	input  logic [63:0]         write_issuable_mask,
	input  logic [63:0]         write_hit_mask,
	output logic                issue_valid,
	output logic                issue_is_write,
	output logic [5:0]          issue_slot,
	output logic                drain_active,
	output logic [3:0]          next_thread
);
	import frrr_pkg::*;

	// Captured input word.
	logic        action_q;
	logic [5:0]  slot_q;
	logic [3:0]  tid_q;
	logic [63:0] rvm_q, rim_q, rhm_q, wim_q, whm_q;
	logic [6:0]  wcount_q;

	// Thread owner per read slot, one compare cell each.
	logic [3:0] thr_q [QUEUE_DEPTH];

	// Scheduler state.
	logic       drain_q, empty_q;
	logic [6:0] tally_q;
	logic [3:0] ptr_q;

	// Output register.
	logic       iv_q, iw_q, da_q;
	logic [5:0] is_q;
	logic [3:0] nt_q;

	logic [63:0] rvalid, wvalid, riss, rhit, wiss, thr_hit;
	logic        reads_present;
	logic        dm, fe;
	logic [6:0]  tally_d;
	logic [3:0]  ptr_d;
	logic [4:0]  cnt_eff, ptr_inc;
	logic        adv;
	frrr_pick_t  p_whit, p_wiss, p_rtl, p_rhit, p_itl, p_riss, pick;
	logic        pick_write;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			slot_q   <= slot;
			tid_q    <= owner_thread;
			rvm_q    <= read_valid_mask;
			rim_q    <= read_issuable_mask;
			rhm_q    <= read_hit_mask;
			wcount_q <= write_count;
			wim_q    <= write_issuable_mask;
			whm_q    <= write_hit_mask;
		end
		if (cmd.commit && action_q == ACT_STORE && 7'(slot_q) < 7'(QUEUE_DEPTH))
			thr_q[slot_q] <= tid_q;
	end

	always_comb begin
		for (int i = 0; i < 64; i++) begin
			wvalid[i]  = (7'(i) < wcount_q) & QUEUE_MASK[i];
			thr_hit[i] = (i < QUEUE_DEPTH) ? (thr_q[i] == ptr_q) : 1'b0;
		end
	end

	assign rvalid        = rvm_q & QUEUE_MASK;
	assign reads_present = |rvalid;
	assign riss          = rvalid & rim_q;
	assign rhit          = riss & rhm_q;
	assign wiss          = wim_q & wvalid;

	// Drain mode update, evaluated in the same order each step.
	always_comb begin
		dm      = drain_q;
		fe      = empty_q;
		tally_d = tally_q;
		if (wcount_q > cfg.high_watermark && !dm) begin
			dm      = 1'b1;
			tally_d = 7'd0;
		end
		if (!reads_present && wcount_q != 7'd0 && !dm) begin
			dm      = 1'b1;
			tally_d = 7'd0;
			fe      = 1'b1;
		end
		if (dm && wcount_q <= cfg.low_watermark && !fe) dm = 1'b0;
		if (dm && reads_present && fe && tally_d > cfg.min_drain_writes) begin
			dm = 1'b0;
			fe = 1'b0;
		end
		if (wcount_q == 7'd0) dm = 1'b0;
	end

	assign p_whit = lowest_set(wiss & whm_q);
	assign p_wiss = lowest_set(wiss);
	assign p_rtl  = lowest_set(rhit & thr_hit);
	assign p_rhit = lowest_set(rhit);
	assign p_itl  = lowest_set(riss & thr_hit);
	assign p_riss = lowest_set(riss);

	always_comb begin
		cnt_eff = cfg.core_count;
		if (cnt_eff == 5'd0) cnt_eff = 5'd1;
		if (cnt_eff > 5'(MAX_THREADS)) cnt_eff = 5'(MAX_THREADS);
		ptr_inc = {1'b0, ptr_q} + 5'd1;
	end

	always_comb begin
		adv        = 1'b0;
		pick_write = 1'b0;
		if (dm) begin
			pick       = p_whit.found ? p_whit : p_wiss;
			pick_write = pick.found;
		end else if (p_rtl.found) begin
			pick = p_rtl;
			adv  = 1'b1;
		end else if (p_rhit.found) begin
			pick = p_rhit;
		end else if (p_itl.found) begin
			pick = p_itl;
			adv  = 1'b1;
		end else begin
			pick = p_riss;
		end
		ptr_d = ptr_q;
		if (adv) ptr_d = (ptr_inc >= cnt_eff) ? 4'd0 : ptr_inc[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			empty_q <= 1'b0;
			tally_q <= 7'd0;
			ptr_q   <= 4'd0;
		end else if (cmd.commit && action_q == ACT_SCHED) begin
			drain_q <= dm;
			empty_q <= fe;
			ptr_q   <= ptr_d;
			// Count row-hit writes, saturating.
			if (dm && p_whit.found && tally_d != 7'd127) tally_q <= tally_d + 7'd1;
			else tally_q <= tally_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (action_q == ACT_STORE) begin
				iv_q <= 1'b0;
				iw_q <= 1'b0;
				is_q <= 6'd0;
				da_q <= drain_q;
				nt_q <= ptr_q;
			end else begin
				iv_q <= pick.found;
				iw_q <= pick_write;
				is_q <= pick.idx;
				da_q <= dm;
				nt_q <= ptr_d;
			end
		end
	end

	assign issue_valid    = iv_q;
	assign issue_is_write = iw_q;
	assign issue_slot     = is_q;
	assign drain_active   = da_q;
	assign next_thread    = nt_q;
endmodule

// ----- hw/rtl/dram_frrr_command_scheduler_core.sv -----
`timescale 1ns / 1ps
// Flow: a word is captured on acceptance, picked from the captured registers in the
// execute state, and loaded into the output register on commit, once that register is free.
// The one-slot controller takes no new word until the current one has been committed.
// Reset: arst_n clears drain mode, the tally, the thread pointer and all handshake
// state, and loads the configuration defaults; the thread-id table is not cleared.
`include "dram_frrr_command_scheduler_core_defines.svh"
module dram_frrr_command_scheduler_core (
	input  logic        clk,
	input  logic        arst_n,
	frrr_req_if.sink    req,
	frrr_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import frrr_pkg::*;

	frrr_cmd_t cmd;
	frrr_cfg_t cfg;

	// Watermarks, drain minimum and thread count, written over APB.
	frrr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Controller: take one word, hold it in the execute state for the pick, then commit
	// once the output register is free. A new word may be taken while the
	// previous result still waits downstream.
	frrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd)
	);

	// Datapath: input capture, thread-id cells, drain-mode update, the six
	// priority encoders and the output register.
	frrr_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.cfg                 (cfg),
		.action              (req.action),
		.slot                (req.slot),
		.owner_thread        (req.owner_thread),
		.read_valid_mask     (req.read_valid_mask),
		.read_issuable_mask  (req.read_issuable_mask),
		.read_hit_mask       (req.read_hit_mask),
		.write_count         (req.write_count),
		.write_issuable_mask (req.write_issuable_mask),
		.write_hit_mask      (req.write_hit_mask),
		.issue_valid         (rsp.issue_valid),
		.issue_is_write      (rsp.issue_is_write),
		.issue_slot          (rsp.issue_slot),
		.drain_active        (rsp.drain_active),
		.next_thread         (rsp.next_thread)
	);

	// A write pick only happens in drain mode.
	`FRRR_ASSERT_NOW(a_write_in_drain, clk, arst_n, rsp.valid && rsp.issue_is_write, rsp.issue_valid && rsp.drain_active)
	// One word in flight: acceptance drops ready while the word is picked.
	`FRRR_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req.valid && req.ready, !req.ready)
	// Every commit shows a result on the next cycle.
	`FRRR_ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, rsp.valid)
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Scheduler bench: directed table first, then random phases under several register
// settings. Every accepted word is run through a local scheduler model and the
// result words are compared, field by field, in order.
module tb_top;
	import frrr_pkg::*;

	localparam int          CYCLE_LIMIT = 200000;
	localparam logic [63:0] ALL_SLOTS   = {64{1'b1}};
	localparam logic [63:0] TOP_SLOT    = 64'h8000_0000_0000_0000;

	// One request word as it crosses the request channel.
	typedef struct packed {
		logic        action;
		logic [5:0]  slot;
		logic [3:0]  owner_thread;
		logic [63:0] read_valid_mask;
		logic [63:0] read_issuable_mask;
		logic [63:0] read_hit_mask;
		logic [6:0]  write_count;
		logic [63:0] write_issuable_mask;
		logic [63:0] write_hit_mask;
	} sched_word_t;

	// One result word: the command picked and the mode after the pick.
	typedef struct packed {
		logic       issue_valid;
		logic       issue_is_write;
		logic [5:0] issue_slot;
		logic       drain_active;
		logic [3:0] next_thread;
	} pick_t;

	typedef struct {
		sched_word_t w;
		bit          typed;
		pick_t       want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	frrr_req_if req_bus ();
	frrr_rsp_if rsp_bus ();

	dram_frrr_command_scheduler_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_bus),
		.rsp     (rsp_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Scheduler model state: thread table, drain mode and the thread pointer.
	logic [3:0]  slot_owner [64];
	logic [63:0] owner_known;
	logic        drain_on;
	logic        drain_dry;
	logic [6:0]  drain_hits;
	logic [3:0]  rr_ptr;

	// Model copy of the configuration registers.
	logic [6:0]  hw_mark;
	logic [6:0]  lw_mark;
	logic [6:0]  min_hits;
	logic [4:0]  core_cnt;

	pick_t       pending_picks [$];
	dir_row_t    dir_rows [$];
	int          errors = 0;
	longint      cycles = 0;
	bit          calm = 1'b0;
	int          gap_pct = 20;
	int          stall_pct = 20;
	int          wc_level = 0;
	int          dry_left = 0;

	always #5 clk = ~clk;

	// Give up on a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int first_one(input logic [63:0] m);
		for (int i = 0; i < 64; i++)
			if (m[i])
				return i;
		return -1;
	endfunction

	function automatic int first_of_thread(input logic [63:0] m, input logic [3:0] thr);
		for (int i = 0; i < 64; i++)
			if (m[i] && slot_owner[i] == thr)
				return i;
		return -1;
	endfunction

	// Threads the pointer walks over: zero acts as one, clamp at the maximum.
	function automatic int thread_span();
		if (core_cnt == 0)
			return 1;
		if (core_cnt > MAX_THREADS)
			return MAX_THREADS;
		return int'(core_cnt);
	endfunction

	function automatic void step_pointer();
		rr_ptr = (int'(rr_ptr) + 1 >= thread_span()) ? 4'd0 : rr_ptr + 4'd1;
	endfunction

	// Advance the model by one accepted word and return the result word it causes.
	function automatic pick_t predict_pick(input sched_word_t w);
		pick_t       p;
		logic [63:0] rvalid;
		logic [63:0] wvalid;
		logic [63:0] wiss;
		logic [63:0] riss;
		logic [63:0] rhit;
		int          wc;
		int          idx;
		bit          is_wr;
		bit          reads_in;
		p = '0;
		is_wr = 1'b0;
		idx = -1;
		if (w.action == ACT_STORE) begin
			slot_owner[w.slot] = w.owner_thread;
			owner_known[w.slot] = 1'b1;
			p.drain_active = drain_on;
			p.next_thread = rr_ptr;
			return p;
		end
		wc = int'(w.write_count);
		rvalid = w.read_valid_mask & QUEUE_MASK;
		wvalid = ((wc >= 64) ? ALL_SLOTS : ((64'd1 << wc) - 64'd1)) & QUEUE_MASK;
		reads_in = (rvalid != 0);

		// Enter drain above the high mark, or when reads run dry with writes waiting.
		if (wc > hw_mark && !drain_on) begin
			drain_on = 1'b1;
			drain_hits = '0;
		end
		if (!reads_in && wc > 0 && !drain_on) begin
			drain_on = 1'b1;
			drain_hits = '0;
			drain_dry = 1'b1;
		end
		// Leave at the low mark unless the drain began for empty reads.
		if (drain_on && wc <= lw_mark && !drain_dry)
			drain_on = 1'b0;
		if (drain_on && reads_in && drain_dry && drain_hits > min_hits) begin
			drain_on = 1'b0;
			drain_dry = 1'b0;
		end
		if (wc == 0)
			drain_on = 1'b0;

		if (drain_on) begin
			// Writes: row hit first, then anything issuable, oldest slot first.
			wiss = w.write_issuable_mask & wvalid;
			idx = first_one(wiss & w.write_hit_mask);
			if (idx >= 0) begin
				if (drain_hits != 7'd127)
					drain_hits = drain_hits + 7'd1;
			end else begin
				idx = first_one(wiss);
			end
			is_wr = (idx >= 0);
		end else begin
			// Reads: hit of the pointed thread, any hit, issuable of the thread, any.
			riss = rvalid & w.read_issuable_mask;
			rhit = riss & w.read_hit_mask;
			idx = first_of_thread(rhit, rr_ptr);
			if (idx >= 0) begin
				step_pointer();
			end else begin
				idx = first_one(rhit);
				if (idx < 0) begin
					idx = first_of_thread(riss, rr_ptr);
					if (idx >= 0)
						step_pointer();
					else
						idx = first_one(riss);
				end
			end
		end

		p.issue_valid = (idx >= 0);
		p.issue_is_write = is_wr;
		p.issue_slot = (idx >= 0) ? 6'(idx) : 6'd0;
		p.drain_active = drain_on;
		p.next_thread = rr_ptr;
		return p;
	endfunction

	function automatic logic [63:0] rand_mask();
		logic [63:0] a;
		logic [63:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return '0;
			1: return ALL_SLOTS;
			2: return a & b & {$urandom, $urandom};
			3: return a | b;
			default: return a;
		endcase
	endfunction

	function automatic pick_t pk(input logic iv, input logic iw, input logic [5:0] s,
			input logic da, input logic [3:0] nt);
		pick_t p;
		p.issue_valid = iv;
		p.issue_is_write = iw;
		p.issue_slot = s;
		p.drain_active = da;
		p.next_thread = nt;
		return p;
	endfunction

	function automatic dir_row_t mk_row(input logic act, input logic [5:0] s,
			input logic [3:0] tid, input logic [63:0] rv, input logic [63:0] ri,
			input logic [63:0] rh, input logic [6:0] wc, input logic [63:0] wi,
			input logic [63:0] wh, input bit typed, input pick_t want);
		dir_row_t r;
		r.w.action = act;
		r.w.slot = s;
		r.w.owner_thread = tid;
		r.w.read_valid_mask = rv;
		r.w.read_issuable_mask = ri;
		r.w.read_hit_mask = rh;
		r.w.write_count = wc;
		r.w.write_issuable_mask = wi;
		r.w.write_hit_mask = wh;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	task automatic flag_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Compare one result word with the oldest expectation.
	task automatic check_pick(input pick_t got);
		pick_t want;
		if (pending_picks.size() == 0) begin
			errors++;
			$display("%0t: result word with nothing pending: expected none, actual %h",
				$time, got);
			return;
		end
		want = pending_picks.pop_front();
		flag_field("issue_valid", want.issue_valid, got.issue_valid);
		flag_field("issue_is_write", want.issue_is_write, got.issue_is_write);
		flag_field("issue_slot", want.issue_slot, got.issue_slot);
		flag_field("drain_active", want.drain_active, got.drain_active);
		flag_field("next_thread", want.next_thread, got.next_thread);
	endtask

	// Offer one word, hold it until accepted, then queue what it must produce.
	task automatic send_word(input sched_word_t w, input bit typed, input pick_t want);
		pick_t guess;
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.action <= w.action;
		req_bus.slot <= w.slot;
		req_bus.owner_thread <= w.owner_thread;
		req_bus.read_valid_mask <= w.read_valid_mask;
		req_bus.read_issuable_mask <= w.read_issuable_mask;
		req_bus.read_hit_mask <= w.read_hit_mask;
		req_bus.write_count <= w.write_count;
		req_bus.write_issuable_mask <= w.write_issuable_mask;
		req_bus.write_hit_mask <= w.write_hit_mask;
		do
			@(posedge clk);
		while (req_bus.ready !== 1'b1);
		guess = predict_pick(w);
		pending_picks.push_back(typed ? want : guess);
	endtask

	// Drop valid and wait out every pending result plus the pipeline tail.
	task automatic settle();
		req_bus.valid <= 1'b0;
		while (pending_picks.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Write one register over the bus, then read it back.
	task automatic program_reg(input frrr_reg_t r, input logic [31:0] v);
		logic [31:0] keep;
		keep = (r == REG_CORE_CNT) ? (v & 32'h1f) : (v & 32'h7f);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		case (r)
			REG_HIGH_WM:   hw_mark = keep[6:0];
			REG_LOW_WM:    lw_mark = keep[6:0];
			REG_MIN_DRAIN: min_hits = keep[6:0];
			REG_CORE_CNT:  core_cnt = keep[4:0];
			default: ;
		endcase
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		if (prdata !== keep) begin
			errors++;
			$display("%0t: register %s read back: expected %0d, actual %0d",
				$time, r.name(), keep, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Random words for one register setting. Stores come more often until every slot
	// has an owner; schedule words drift the write count toward and away from the
	// watermarks and starve reads in short runs to enter and leave both drain modes.
	task automatic run_phase(input int n);
		sched_word_t w;
		int          step;
		gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
		stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
		for (int k = 0; k < n; k++) begin
			w.slot = 6'($urandom);
			w.owner_thread = ($urandom_range(0, 3) != 0) ?
				4'($urandom_range(0, thread_span() - 1)) : 4'($urandom);
			w.read_valid_mask = rand_mask();
			w.read_issuable_mask = rand_mask();
			w.read_hit_mask = rand_mask();
			w.write_issuable_mask = rand_mask();
			w.write_hit_mask = rand_mask();
			w.write_count = 7'($urandom);
			if ($urandom_range(0, 99) < ((owner_known == ALL_SLOTS) ? 12 : 40)) begin
				w.action = ACT_STORE;
			end else begin
				w.action = ACT_SCHED;
				// Never show a read slot whose owner was not stored yet.
				w.read_valid_mask &= owner_known;
				if (dry_left > 0) begin
					dry_left--;
					w.read_valid_mask = '0;
				end else if ($urandom_range(0, 24) == 0) begin
					dry_left = $urandom_range(2, 8);
				end
				case ($urandom_range(0, 19))
					0: wc_level = $urandom_range(0, 127);
					1: wc_level = 0;
					2: wc_level = int'(hw_mark) + 1;
					3: wc_level = int'(lw_mark);
					default: begin
						step = $urandom_range(0, 3);
						wc_level = drain_on ? wc_level - step : wc_level + step;
					end
				endcase
				if (wc_level < 0)
					wc_level = 0;
				if (wc_level > 127)
					wc_level = 127;
				w.write_count = 7'(wc_level);
			end
			send_word(w, 1'b0, '0);
		end
		settle();
	endtask

	// Response side: check each accepted result word, stall in random bursts.
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
				check_pick({rsp_bus.issue_valid, rsp_bus.issue_is_write, rsp_bus.issue_slot,
					rsp_bus.drain_active, rsp_bus.next_thread});
			if (stall_left > 0) begin
				stall_left--;
				rsp_bus.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(0, 9);
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	// Request side and test sequence.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_bus.valid = 1'b0;
		req_bus.action = ACT_STORE;
		req_bus.slot = '0;
		req_bus.owner_thread = '0;
		req_bus.read_valid_mask = '0;
		req_bus.read_issuable_mask = '0;
		req_bus.read_hit_mask = '0;
		req_bus.write_count = '0;
		req_bus.write_issuable_mask = '0;
		req_bus.write_hit_mask = '0;

		// Model reset: register defaults, idle pointer, no drain.
		hw_mark = 7'd40;
		lw_mark = 7'd32;
		min_hits = 7'd1;
		core_cnt = 5'd4;
		owner_known = '0;
		drain_on = 1'b0;
		drain_dry = 1'b0;
		drain_hits = '0;
		rr_ptr = '0;
		foreach (slot_owner[i])
			slot_owner[i] = '0;

		// Stores into both end slots and a few owners for the pointer cases.
		dir_rows.push_back(mk_row(ACT_STORE, 0, 0, 0, 0, 0, 0, 0, 0, 1, pk(0, 0, 0, 0, 0)));
		dir_rows.push_back(mk_row(ACT_STORE, 63, 15, 0, 0, 0, 0, 0, 0, 1, pk(0, 0, 0, 0, 0)));
		dir_rows.push_back(mk_row(ACT_STORE, 1, 1, 0, 0, 0, 0, 0, 0, 1, pk(0, 0, 0, 0, 0)));
		dir_rows.push_back(mk_row(ACT_STORE, 2, 2, 0, 0, 0, 0, 0, 0, 1, pk(0, 0, 0, 0, 0)));
		// Nothing queued at all: no pick.
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, 0, 0, 0, 0, 0, 0, 1, pk(0, 0, 0, 0, 0)));
		// Hit of the pointed thread: pick it and advance.
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, 1, 1, 1, 0, 0, 0, 1, pk(1, 0, 0, 0, 1)));
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, TOP_SLOT | 3, ALL_SLOTS, ALL_SLOTS, 0, 0, 0,
			1, pk(1, 0, 1, 0, 2)));
		// Any hit when the pointed thread has none: hold the pointer.
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, TOP_SLOT | 1, ALL_SLOTS, TOP_SLOT, 0, 0, 0,
			1, pk(1, 0, 63, 0, 2)));
		// No hits: issuable of the pointed thread advances, plain oldest holds.
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, 5, 5, 0, 0, 0, 0, 1, pk(1, 0, 2, 0, 3)));
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, 3, 3, 0, 0, 0, 0, 1, pk(1, 0, 0, 0, 3)));
		// Reads present but none issuable.
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, TOP_SLOT | 1, 0, ALL_SLOTS, 0, 0, 0,
			1, pk(0, 0, 0, 0, 3)));
		// Empty reads with a write waiting: drain, then stay until the hit tally
		// passes the minimum, even at or below the low mark.
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, 0, 0, 0, 1, 1, 1, 1, pk(1, 1, 0, 1, 3)));
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, 1, 1, 1, 1, 1, 1, 1, pk(1, 1, 0, 1, 3)));
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, 1, 1, 1, 1, 1, 1, 1, pk(1, 0, 0, 0, 3)));
		// Full write queue over the high mark: row hit wins over older slots.
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, 1, 0, 0, 64, ALL_SLOTS, TOP_SLOT,
			1, pk(1, 1, 63, 1, 3)));
		// Count beyond the queue depth, no hits: oldest issuable.
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, 1, 0, 0, 127, ALL_SLOTS, 0,
			1, pk(1, 1, 0, 1, 3)));
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, 1, 0, 0, 33, 0, ALL_SLOTS,
			1, pk(0, 0, 0, 1, 3)));
		// At the low mark the watermark drain ends.
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, 2, 2, 2, 32, ALL_SLOTS, ALL_SLOTS,
			1, pk(1, 0, 1, 0, 3)));
		// One above the high mark: only slot 40 can go.
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, 1, 0, 0, 41, 64'd1 << 40, 0,
			1, pk(1, 1, 40, 1, 3)));
		// Write count zero forces read mode.
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, 4, 4, 0, 0, ALL_SLOTS, ALL_SLOTS,
			1, pk(1, 0, 2, 0, 3)));
		// Pointer wraps past the last thread.
		dir_rows.push_back(mk_row(ACT_STORE, 3, 3, 0, 0, 0, 0, 0, 0, 1, pk(0, 0, 0, 0, 3)));
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, 8, 8, 8, 0, 0, 0, 1, pk(1, 0, 3, 0, 0)));
		dir_rows.push_back(mk_row(ACT_STORE, 42, 10, 0, 0, 0, 0, 0, 0, 1, pk(0, 0, 0, 0, 0)));
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, 64'h0000_0400_0000_000F,
			64'h0000_0400_0000_000A, 64'h0000_0400_0000_0008, 20, ALL_SLOTS, ALL_SLOTS,
			0, '0));
		dir_rows.push_back(mk_row(ACT_SCHED, 0, 0, 0, 0, 0, 20, 64'hF0, 0, 0, '0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
		settle();

		run_phase(100);

		// Low extremes: drain on any write, a watermark drain ends only with no writes.
		program_reg(REG_HIGH_WM, 0);
		program_reg(REG_LOW_WM, 0);
		program_reg(REG_MIN_DRAIN, 0);
		program_reg(REG_CORE_CNT, 1);
		run_phase(100);

		// High extremes: full thread count, empty-read drain hard to leave.
		program_reg(REG_HIGH_WM, 64);
		program_reg(REG_LOW_WM, 64);
		program_reg(REG_MIN_DRAIN, 127);
		program_reg(REG_CORE_CNT, 16);
		run_phase(100);

		// Out-of-range settings: no watermark drain, thread count of zero.
		program_reg(REG_HIGH_WM, 127);
		program_reg(REG_LOW_WM, 0);
		program_reg(REG_MIN_DRAIN, 127);
		program_reg(REG_CORE_CNT, 0);
		run_phase(100);

		// Tight marks and a thread count above the maximum.
		program_reg(REG_HIGH_WM, 10);
		program_reg(REG_LOW_WM, 5);
		program_reg(REG_MIN_DRAIN, 3);
		program_reg(REG_CORE_CNT, 31);
		run_phase(100);

		// Random setting, then a closing stretch with no idling on either side.
		program_reg(REG_HIGH_WM, $urandom_range(0, 64));
		program_reg(REG_LOW_WM, $urandom_range(0, 64));
		program_reg(REG_MIN_DRAIN, $urandom_range(0, 8));
		program_reg(REG_CORE_CNT, $urandom_range(1, 16));
		run_phase(60);
		calm = 1'b1;
		run_phase(60);

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
